@@ rtl/tdmh_pkg.sv @@
// ============================================================================
// tdmh_pkg: shared types and helpers of the timer deadline heap
// Item layouts, opcode and status codes, wrap-aware distance from now.
// ============================================================================
package tdmh_pkg;

    localparam logic [31:0] LATE_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  timer_tag;
        logic [31:0] deadline;
        logic [31:0] period;
        logic        repeat_mode;
        logic [31:0] now_time;
    } cmd_t;

    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_tag;
        status_t     status;
        logic [4:0]  timer_count;
        logic        head_valid;
        logic [31:0] head_deadline;
    } rsp_t;

    function automatic logic [31:0] due_dist(input logic [31:0] dl, input logic [31:0] now);
        logic [31:0] x;
        x = dl - now;
        return (x > LATE_LIMIT) ? 32'd0 : x;
    endfunction

endpackage

@@ rtl/timer_deadline_min_heap.sv @@
// ============================================================================
// timer_deadline_min_heap: binary min-heap timer scheduler
// Row of slot cells driven by a sift sequencer; one result item per item.
// ============================================================================
// The block holds up to HEAP_DEPTH timers ordered by wrap-aware distance from
// the item's now_time and returns one result item for every command item. It
// works on one item at a time. A sift step is an indexed read of the cell row
// in one state, then a compare and write in the next. A delete first walks a
// token down the cell row, one cell per cycle, and then sifts up or down from
// the hole. A tick that is not due, a refused insert and a no-op go straight
// from idle to the done state. The next item is taken while the last result
// still waits.
module timer_deadline_min_heap #(
    parameter int HEAP_DEPTH = 16,
    parameter int TAG_BITS   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  tdmh_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tdmh_pkg::rsp_t rsp
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int CHW   = $clog2(2 * HEAP_DEPTH + 1);
    localparam int ENT_W = TAG_BITS + 65;
    localparam int DL_LO = TAG_BITS;
    localparam int PR_LO = TAG_BITS + 32;
    localparam int RP_B  = TAG_BITS + 64;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SEARCH  = 8'b0000_0010,
        S_LAST_RD = 8'b0000_0100,
        S_UP_RD   = 8'b0000_1000,
        S_UP_WR   = 8'b0001_0000,
        S_DN_RD   = 8'b0010_0000,
        S_DN_WR   = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   h_reg, h_next;
    logic [ENT_W-1:0]   x_reg, x_next;
    logic [ENT_W-1:0]   rda_reg, rdb_reg;
    logic [31:0]        now_reg, now_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic               ud_reg, ud_next;
    logic               moved_reg, moved_next;
    logic               fired_reg, fired_next;
    logic [TAG_BITS-1:0] ftag_reg, ftag_next;
    tdmh_pkg::status_t  status_reg, status_next;
    tdmh_pkg::rsp_t     rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               wr_en;
    logic [CHW-1:0]     wr_idx, rd_a_idx, rd_b_idx;
    logic [ENT_W-1:0]   wr_entry;
    logic               search_start;

    logic [ENT_W-1:0]   rd_a_all [HEAP_DEPTH];
    logic [ENT_W-1:0]   rd_b_all [HEAP_DEPTH];
    logic [ENT_W-1:0]   head_entry;
    logic [HEAP_DEPTH:0] tok;
    logic [HEAP_DEPTH-1:0] hit, dead;
    logic [ENT_W-1:0]   bus_a, bus_b;
    logic [IDX_W-1:0]   found_idx;
    logic               any_hit, any_dead;

    logic [TAG_BITS+7:0] tag_wide, ftag_wide;
    logic [CNT_W+4:0]   cnt_wide;
    logic [TAG_BITS-1:0] tag_in;
    logic [IDX_W-1:0]   parent;
    logic [CHW-1:0]     left, right;
    logic               l_live, r_live;
    logic [31:0]        dx, dp, dl_d, dr_d, best;
    logic [1:0]         low_sel;
    logic [CNT_W-1:0]   count_dec;

    assign tok[0] = search_start;

    for (genvar k = 0; k < HEAP_DEPTH; k++)
    begin : g_cell
        logic [ENT_W-1:0] cell_entry;

        tdmh_cell #(
            .CELL_INDEX (k),
            .TAG_BITS   (TAG_BITS),
            .IDX_BITS   (CHW),
            .CNT_BITS   (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (wr_en),
            .wr_idx     (wr_idx),
            .wr_entry   (wr_entry),
            .rd_a_idx   (rd_a_idx),
            .rd_b_idx   (rd_b_idx),
            .rd_a_entry (rd_a_all[k]),
            .rd_b_entry (rd_b_all[k]),
            .entry      (cell_entry),
            .count      (count_reg),
            .search_tag (tag_reg),
            .tok_in     (tok[k]),
            .tok_out    (tok[k+1]),
            .hit        (hit[k]),
            .dead       (dead[k])
        );

        if (k == 0)
        begin : g_head
            assign head_entry = cell_entry;
        end
    end

    always_comb
    begin
        bus_a     = '0;
        bus_b     = '0;
        found_idx = '0;
        for (int k = 0; k < HEAP_DEPTH; k++)
        begin
            bus_a     = bus_a | rd_a_all[k];
            bus_b     = bus_b | rd_b_all[k];
            found_idx = found_idx | (hit[k] ? IDX_W'(k) : '0);
        end
    end

    assign any_hit  = |hit;
    assign any_dead = (|dead) || tok[HEAP_DEPTH];

    assign tag_wide  = {{TAG_BITS{1'b0}}, cmd.timer_tag};
    assign tag_in    = tag_wide[TAG_BITS-1:0];
    assign ftag_wide = {8'b0, ftag_reg};
    assign cnt_wide  = {5'b0, count_reg};

    assign count_dec = count_reg - 1'b1;
    assign parent    = (h_reg - 1'b1) >> 1;
    assign left      = (CHW'(h_reg) << 1) + CHW'(1);
    assign right     = (CHW'(h_reg) << 1) + CHW'(2);
    assign l_live    = left < CHW'(count_reg);
    assign r_live    = right < CHW'(count_reg);

    assign dx   = tdmh_pkg::due_dist(x_reg[DL_LO +: 32], now_reg);
    assign dp   = tdmh_pkg::due_dist(rda_reg[DL_LO +: 32], now_reg);
    assign dl_d = tdmh_pkg::due_dist(rda_reg[DL_LO +: 32], now_reg);
    assign dr_d = tdmh_pkg::due_dist(rdb_reg[DL_LO +: 32], now_reg);

    always_comb
    begin
        low_sel = 2'd0;
        best    = dx;
        if (l_live && (dl_d < best))
        begin
            low_sel = 2'd1;
            best    = dl_d;
        end
        if (r_live && (dr_d < best))
        begin
            low_sel = 2'd2;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        h_next         = h_reg;
        x_next         = x_reg;
        now_next       = now_reg;
        tag_next       = tag_reg;
        ud_next        = ud_reg;
        moved_next     = moved_reg;
        fired_next     = fired_reg;
        ftag_next      = ftag_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        wr_en          = 1'b0;
        wr_idx         = CHW'(h_reg);
        wr_entry       = x_reg;
        rd_a_idx       = '0;
        rd_b_idx       = '0;
        search_start   = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    now_next    = cmd.now_time;
                    tag_next    = tag_in;
                    fired_next  = 1'b0;
                    ftag_next   = '0;
                    status_next = tdmh_pkg::ST_OK;
                    ud_next     = 1'b0;
                    moved_next  = 1'b0;
                    state_next  = S_DONE;
                    unique case (cmd.opcode)
                        tdmh_pkg::OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(HEAP_DEPTH))
                            begin
                                status_next = tdmh_pkg::ST_FULL;
                            end
                            else
                            begin
                                x_next     = {cmd.repeat_mode, cmd.period, cmd.deadline,
                                              tag_in};
                                h_next     = IDX_W'(count_reg);
                                count_next = count_reg + 1'b1;
                                state_next = S_UP_RD;
                            end
                        end
                        tdmh_pkg::OP_DELETE:
                        begin
                            search_start = 1'b1;
                            ud_next      = 1'b1;
                            state_next   = S_SEARCH;
                        end
                        tdmh_pkg::OP_TICK:
                        begin
                            if ((count_reg != '0) &&
                                (tdmh_pkg::due_dist(head_entry[DL_LO +: 32], cmd.now_time)
                                 == 32'd0))
                            begin
                                fired_next = 1'b1;
                                ftag_next  = head_entry[TAG_BITS-1:0];
                                h_next     = '0;
                                if (head_entry[RP_B])
                                begin
                                    x_next     = head_entry;
                                    x_next[DL_LO +: 32] = head_entry[DL_LO +: 32] +
                                                          head_entry[PR_LO +: 32];
                                    state_next = S_DN_RD;
                                end
                                else
                                begin
                                    count_next = count_dec;
                                    if (count_dec != '0)
                                    begin
                                        state_next = S_LAST_RD;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (any_hit)
                begin
                    count_next = count_dec;
                    h_next     = found_idx;
                    if (found_idx == IDX_W'(count_dec))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LAST_RD;
                    end
                end
                else if (any_dead)
                begin
                    status_next = tdmh_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end
            S_LAST_RD:
            begin
                rd_a_idx   = CHW'(count_reg);
                x_next     = bus_a;
                state_next = ud_reg ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD:
            begin
                if (h_reg == '0)
                begin
                    if (ud_reg && !moved_reg)
                    begin
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    rd_a_idx   = CHW'(parent);
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                if (dx < dp)
                begin
                    wr_en      = 1'b1;
                    wr_entry   = rda_reg;
                    h_next     = parent;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end
                else if (ud_reg && !moved_reg)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_RD:
            begin
                rd_a_idx   = left;
                rd_b_idx   = right;
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                wr_en = 1'b1;
                case (low_sel)
                    2'd1:
                    begin
                        wr_entry   = rda_reg;
                        h_next     = IDX_W'(left);
                        state_next = S_DN_RD;
                    end
                    2'd2:
                    begin
                        wr_entry   = rdb_reg;
                        h_next     = IDX_W'(right);
                        state_next = S_DN_RD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.fired         = fired_reg;
                    rsp_next.fired_tag     = ftag_wide[7:0];
                    rsp_next.status        = status_reg;
                    rsp_next.timer_count   = cnt_wide[4:0];
                    rsp_next.head_valid    = (count_reg != '0);
                    rsp_next.head_deadline = (count_reg != '0) ?
                                             head_entry[DL_LO +: 32] : 32'd0;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        x_reg      <= x_next;
        rda_reg    <= bus_a;
        rdb_reg    <= bus_b;
        now_reg    <= now_next;
        tag_reg    <= tag_next;
        ud_reg     <= ud_next;
        moved_reg  <= moved_next;
        fired_reg  <= fired_next;
        ftag_reg   <= ftag_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/tdmh_cell.sv @@
// ============================================================================
// tdmh_cell: one heap slot of the timer row
// Holds one timer, answers indexed reads, and passes the search token on.
// ============================================================================
module tdmh_cell #(
    parameter int CELL_INDEX = 0,
    parameter int TAG_BITS   = 8,
    parameter int IDX_BITS   = 6,
    parameter int CNT_BITS   = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IDX_BITS-1:0]   wr_idx,
    input  logic [TAG_BITS+64:0]  wr_entry,
    input  logic [IDX_BITS-1:0]   rd_a_idx,
    input  logic [IDX_BITS-1:0]   rd_b_idx,
    output logic [TAG_BITS+64:0]  rd_a_entry,
    output logic [TAG_BITS+64:0]  rd_b_entry,
    output logic [TAG_BITS+64:0]  entry,
    input  logic [CNT_BITS-1:0]   count,
    input  logic [TAG_BITS-1:0]   search_tag,
    input  logic                  tok_in,
    output logic                  tok_out,
    output logic                  hit,
    output logic                  dead
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);
    localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(CELL_INDEX);

    logic [TAG_BITS+64:0] entry_reg;
    logic                 tok_reg;
    logic                 live;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    assign live       = (MY_CNT < count);
    assign hit        = tok_reg && live && (entry_reg[TAG_BITS-1:0] == search_tag);
    assign dead       = tok_reg && !live;
    assign tok_out    = tok_reg && live && !hit;
    assign entry      = entry_reg;
    assign rd_a_entry = (rd_a_idx == MY_IDX) ? entry_reg : '0;
    assign rd_b_entry = (rd_b_idx == MY_IDX) ? entry_reg : '0;

endmodule
